// ===== design/h_bridge_direction_dead_time_core_macros.svh =====
// Assertion macros for the H-bridge direction core.
// Included by the top level; no other dependencies.
`ifndef H_BRIDGE_DIRECTION_DEAD_TIME_CORE_MACROS_SVH
`define H_BRIDGE_DIRECTION_DEAD_TIME_CORE_MACROS_SVH

// same-cycle implication
`define HBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hbd assertion failed");

// next-cycle implication
`define HBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbd assertion failed");

`endif

// ===== design/hbd_pkg.sv =====
// Shared types, constants and the state-request function of the H-bridge core.
// No dependencies.
package hbd_pkg;

    localparam int DATA_W          = 16;
    localparam int STATE_W         = 2;
    localparam int FUNC_W          = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [DATA_W-1:0] PWM_PERIOD_RST = 16'hFFFF;
    localparam logic [DATA_W-1:0] DEAD_TICKS_RST = 16'd10;

    typedef enum logic [STATE_W-1:0] {
        ST_STOP,
        ST_FWD,
        ST_REV,
        ST_DEAD
    } drive_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_REQ,
        FN_SPEED,
        FN_TICK
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_PERIOD,
        CFG_DEAD_TICKS
    } cfg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] pwm_period;
        logic [DATA_W-1:0] dead_ticks;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [STATE_W-1:0] req_state;
        logic [DATA_W-1:0]  speed;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0]  compare_a;
        logic [DATA_W-1:0]  compare_b;
        logic [STATE_W-1:0] state;
        logic               rejected;
    } res_t;

    typedef struct packed {
        drive_t            drive;
        logic [DATA_W-1:0] ca;
        logic [DATA_W-1:0] cb;
    } drv_t;

    typedef struct packed {
        drv_t   drv;
        logic   start_dead;
        drive_t pending;
    } req_t;

    // One state request; start_dead marks a direct reversal.
    function automatic req_t hbd_request(drv_t cur, drive_t s, logic [DATA_W-1:0] duty);
        req_t r;
        r.drv        = cur;
        r.start_dead = 1'b0;
        r.pending    = s;
        if (!(s == cur.drive && s != ST_DEAD))
        begin
            case (s)
                ST_FWD:
                begin
                    if (cur.drive == ST_REV)
                    begin
                        r.drv.drive  = ST_DEAD;
                        r.drv.ca     = '0;
                        r.drv.cb     = '0;
                        r.start_dead = 1'b1;
                    end
                    else
                    begin
                        r.drv.drive = ST_FWD;
                        r.drv.ca    = duty;
                        r.drv.cb    = '0;
                    end
                end
                ST_REV:
                begin
                    if (cur.drive == ST_FWD)
                    begin
                        r.drv.drive  = ST_DEAD;
                        r.drv.ca     = '0;
                        r.drv.cb     = '0;
                        r.start_dead = 1'b1;
                    end
                    else
                    begin
                        r.drv.drive = ST_REV;
                        r.drv.ca    = '0;
                        r.drv.cb    = duty;
                    end
                end
                default:
                begin
                    r.drv.drive = s;
                    r.drv.ca    = '0;
                    r.drv.cb    = '0;
                end
            endcase
        end
        return r;
    endfunction

endpackage

// ===== design/hbd_ifs.sv =====
// Valid/ready channel interfaces of the H-bridge core: command, result, config.
// Depends on hbd_pkg.
interface hbd_cmd_if import hbd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [STATE_W-1:0]  requested_state;
    logic [DATA_W-1:0]   speed_value;

    modport source (output valid, func, requested_state, speed_value, input ready);
    modport sink   (input valid, func, requested_state, speed_value, output ready);
endinterface

interface hbd_result_if import hbd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   compare_a;
    logic [DATA_W-1:0]   compare_b;
    logic [STATE_W-1:0]  current_state;
    logic                speed_rejected;

    modport source (output valid, compare_a, compare_b, current_state, speed_rejected,
                    input ready);
    modport sink   (input valid, compare_a, compare_b, current_state, speed_rejected,
                    output ready);
endinterface

interface hbd_cfg_if import hbd_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/h_bridge_direction_dead_time_core.sv =====
// H-bridge direction controller with dead time on reversal.
// Channels: cmd (sink) carries func/requested_state/speed_value words; result
// (source) returns one word per command: compare_a, compare_b, current_state,
// speed_rejected. cfg (sink) writes index 0 pwm_period, 1 dead_time_ticks;
// it is always ready and must only be written while no command is in flight.
// A command word is registered on acceptance and processed by the state update
// when it advances, which waits for an empty or draining result register; the
// result register loads the outcome on that edge and then shows it as valid.
// One word per cycle is sustained while result.ready stays high; the state
// update in hbd_ctrl is combinational.
// A stalled result holds its register; the input register still takes one
// more word, then cmd.ready drops until result.ready returns.
// Reset: stop state, both compares 0, duty 0, dead-time timer idle,
// pwm_period 65535, dead_time_ticks 10, both pipeline stages empty.
// Depends on hbd_pkg, hbd_ifs, hbd_cfg, hbd_ctrl and the macros header.
`include "h_bridge_direction_dead_time_core_macros.svh"

module h_bridge_direction_dead_time_core
    import hbd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    hbd_cmd_if.sink      cmd,
    hbd_result_if.source result,
    hbd_cfg_if.sink      cfg
);

    logic  in_valid_reg, in_valid_next;
    item_t in_item_reg;
    logic  res_valid_reg, res_valid_next;
    res_t  res_reg, res_next;
    cfg_t  cfg_regs;
    logic  advance;
    logic  accept;

    assign advance   = in_valid_reg && (!res_valid_reg || result.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign accept    = cmd.valid && cmd.ready;

    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign res_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : res_valid_reg);

    hbd_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    hbd_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_item_reg),
        .cfg   (cfg_regs),
        .res   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= '{cmd.func, cmd.requested_state, cmd.speed_value};
        if (advance)
            res_reg <= res_next;
    end

    assign result.valid          = res_valid_reg;
    assign result.compare_a      = res_reg.compare_a;
    assign result.compare_b      = res_reg.compare_b;
    assign result.current_state  = res_reg.state;
    assign result.speed_rejected = res_reg.rejected;

    `HBD_ASSERT_NOW(a_dead_both_off, clk, rst_n,
        res_valid_reg && res_reg.state == ST_DEAD,
        res_reg.compare_a == '0 && res_reg.compare_b == '0)
    `HBD_ASSERT_NOW(a_one_side_driven, clk, rst_n,
        res_valid_reg && res_reg.compare_a != '0 && res_reg.compare_b != '0,
        1'b0)
    `HBD_ASSERT_NOW(a_stall_only_when_full, clk, rst_n,
        !cmd.ready,
        in_valid_reg && res_valid_reg && !result.ready)
    `HBD_ASSERT_NEXT(a_advance_fills_result, clk, rst_n,
        advance,
        res_valid_reg)

endmodule

// ===== design/hbd_cfg.sv =====
// Configuration register file: PWM period and dead-time length.
// Depends on hbd_pkg and hbd_cfg_if.
module hbd_cfg
    import hbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hbd_cfg_if.sink   cfg,
    output cfg_t      regs
);

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.pwm_period <= PWM_PERIOD_RST;
            regs_reg.dead_ticks <= DEAD_TICKS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_PWM_PERIOD: regs_reg.pwm_period <= cfg.data;
                CFG_DEAD_TICKS: regs_reg.dead_ticks <= cfg.data;
                default:        ;
            endcase
        end
    end

endmodule

// ===== design/hbd_ctrl.sv =====
// Direction/dead-time state and its combinational update for one command word.
// Depends on hbd_pkg.
module hbd_ctrl
    import hbd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    localparam int NEXT_W = COUNT_WIDTH + 1;
    localparam int CMP_W  = (NEXT_W > DATA_W) ? NEXT_W : DATA_W;

    drive_t                 drive_reg,   pending_reg,   pending_next;
    logic [DATA_W-1:0]      ca_reg,      cb_reg,        duty_reg,     duty_next;
    logic [COUNT_WIDTH-1:0] count_reg,   count_next;
    logic                   run_reg,     run_next,      exp_reg,      exp_next;
    logic [NEXT_W-1:0]      count_inc;
    drv_t                   drv_next;
    req_t                   req_a,       req_b;
    logic                   rejected;

    assign count_inc = NEXT_W'(count_reg) + NEXT_W'(1);
    assign req_a     = hbd_request('{drive_reg, ca_reg, cb_reg}, drive_t'(item.req_state),
                                   duty_reg);

    always_comb
    begin
        drv_next     = '{drive_reg, ca_reg, cb_reg};
        pending_next = pending_reg;
        duty_next    = duty_reg;
        count_next   = count_reg;
        run_next     = run_reg;
        exp_next     = exp_reg;
        rejected     = 1'b0;
        req_b        = '0;
        case (item.func)
            FN_REQ:
            begin
                drv_next = req_a.drv;
                if (req_a.start_dead)
                begin
                    pending_next = req_a.pending;
                    exp_next     = 1'b0;
                    count_next   = '0;
                    run_next     = 1'b1;
                end
            end
            FN_SPEED:
            begin
                if (item.speed <= cfg.pwm_period)
                begin
                    duty_next = item.speed;
                    if (drv_next.drive == ST_FWD)
                        drv_next.ca = item.speed;
                    else if (drv_next.drive == ST_REV)
                        drv_next.cb = item.speed;
                end
                else
                    rejected = 1'b1;
            end
            FN_TICK:
            begin
                if (run_reg)
                begin
                    if (CMP_W'(count_inc) >= CMP_W'(cfg.dead_ticks))
                    begin
                        run_next   = 1'b0;
                        exp_next   = 1'b1;
                        count_next = '0;
                    end
                    else
                        count_next = count_inc[COUNT_WIDTH-1:0];
                end
            end
            default: ;
        endcase
        // dead time over: apply the pending direction
        if (drv_next.drive == ST_DEAD && exp_next)
        begin
            exp_next = 1'b0;
            req_b    = hbd_request(drv_next, pending_next, duty_next);
            drv_next = req_b.drv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg   <= ST_STOP;
            pending_reg <= ST_STOP;
            duty_reg    <= '0;
            count_reg   <= '0;
            run_reg     <= 1'b0;
            exp_reg     <= 1'b0;
            ca_reg      <= '0;
            cb_reg      <= '0;
        end
        else if (step)
        begin
            drive_reg   <= drv_next.drive;
            pending_reg <= pending_next;
            duty_reg    <= duty_next;
            count_reg   <= count_next;
            run_reg     <= run_next;
            exp_reg     <= exp_next;
            ca_reg      <= drv_next.ca;
            cb_reg      <= drv_next.cb;
        end
    end

    assign res.compare_a = drv_next.ca;
    assign res.compare_b = drv_next.cb;
    assign res.state     = drv_next.drive;
    assign res.rejected  = rejected;

endmodule
